@@ src/lpn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpn_pkg;

    localparam int BUF_BYTES  = 4096;
    localparam int MAX_DEPTH  = 2048;
    localparam int LEN_W      = 12;
    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
    localparam int MARK_AW    = $clog2(MAX_DEPTH);
    localparam int BANK_SEL_W = 2;
    localparam int BANKS      = 1 << BANK_SEL_W;
    localparam int BANK_AW    = LEN_W - BANK_SEL_W;
    localparam int BANK_DEPTH = BUF_BYTES / BANKS;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    typedef enum logic [1:0] {
        OP_CHAR     = 2'd0,
        OP_END      = 2'd1,
        OP_READ     = 2'd2,
        OP_READ_ALT = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       ch;
        logic [LEN_W-1:0] index;
    } item_t;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [7:0]         data;
    } byte_wr_t;

    typedef struct packed {
        logic               push;
        logic               pop;
        logic [MARK_AW-1:0] wr_addr;
        logic [LEN_W-1:0]   wr_data;
        logic [MARK_AW-1:0] rd_addr;
    } stack_req_t;

    typedef struct packed {
        logic             status;
        logic [LEN_W-1:0] length;
        logic             finished;
        logic             hit;
    } result_t;

endpackage

`default_nettype wire

@@ src/lpn_out_buf.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpn_out_buf
    import lpn_pkg::*;
(
    input  wire logic                 clk,
    input  wire byte_wr_t [BANKS-1:0] wr,
    input  wire logic                 rd_en,
    input  wire logic [LEN_W-1:0]     rd_index,
    output logic [7:0]                rd_byte
);

    logic [7:0]            bank_q [BANKS];
    logic [BANK_SEL_W-1:0] sel_reg;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [7:0] bank_mem [BANK_DEPTH];

        always_ff @(posedge clk)
        begin
            if (wr[b].en)
            begin
                bank_mem[wr[b].addr] <= wr[b].data;
            end
            if (rd_en)
            begin
                bank_q[b] <= bank_mem[rd_index[LEN_W-1:BANK_SEL_W]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sel_reg <= rd_index[BANK_SEL_W-1:0];
        end
    end

    assign rd_byte = bank_q[sel_reg];

endmodule

`default_nettype wire

@@ src/lpn_mark_stack.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpn_mark_stack
    import lpn_pkg::*;
(
    input  wire logic             clk,
    input  wire stack_req_t       req,
    output logic [LEN_W-1:0]      top
);

    logic [LEN_W-1:0] mark_mem [MAX_DEPTH];
    logic [LEN_W-1:0] top_reg;
    logic [LEN_W-1:0] below_reg;

    // below_reg tracks the entry under the top, re-read every cycle
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mark_mem[req.wr_addr] <= req.wr_data;
        end
        below_reg <= mark_mem[req.rd_addr];
        if (req.push)
        begin
            top_reg <= req.wr_data;
        end
        else if (req.pop)
        begin
            top_reg <= below_reg;
        end
    end

    assign top = top_reg;

endmodule

`default_nettype wire

@@ src/lpn_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpn_ctrl
    import lpn_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire item_t                item,
    input  wire logic [LEN_W-1:0]     top,
    output stack_req_t                stack_req,
    output byte_wr_t [BANKS-1:0]      wr,
    output result_t                   result
);

    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [1:0]         seen_reg, seen_next;
    logic [1:0]         held_reg, held_next;
    logic               err_reg, err_next;
    logic               done_reg, done_next;

    logic               is_char, is_end, is_read, is_dot;
    logic               close_pop;
    logic               open_comp, put_c, slash, depth_err;
    logic [1:0]         ndots;
    logic [2:0]         n_bytes, n_put;
    logic [LEN_W-1:0]   room;
    logic [LEN_W-1:0]   base;
    logic [7:0]         seq [4];
    logic [BANK_SEL_W-1:0] kk;
    logic [LEN_W-1:0]   pos;
    logic [DEPTH_W-1:0] rd_depth;

    assign is_char = (item.op == OP_CHAR);
    assign is_end  = (item.op == OP_END);
    assign is_read = !is_char && !is_end;
    assign is_dot  = (item.ch == CH_DOT);
    assign close_pop = (seen_reg != 2'd0) && (held_reg == 2'd2) && (depth_reg != '0);
    assign room = LEN_W'(BUF_BYTES - 1) - len_reg;

    always_comb
    begin
        len_next   = len_reg;
        depth_next = depth_reg;
        seen_next  = seen_reg;
        held_next  = held_reg;
        err_next   = err_reg;
        done_next  = done_reg;
        open_comp  = 1'b0;
        put_c      = 1'b0;
        ndots      = 2'd0;
        slash      = 1'b0;
        depth_err  = 1'b0;
        n_bytes    = 3'd0;
        n_put      = 3'd0;
        base       = len_reg;
        stack_req.push    = 1'b0;
        stack_req.pop     = 1'b0;
        stack_req.wr_addr = depth_reg[MARK_AW-1:0];
        stack_req.wr_data = len_reg;
        for (int i = 0; i < 4; i++)
        begin
            seq[i] = item.ch;
        end

        if (accept && !done_reg)
        begin
            if (is_char && (item.ch != CH_NUL) && !err_reg)
            begin
                if (item.ch == CH_SLASH)
                begin
                    if (close_pop)
                    begin
                        stack_req.pop = 1'b1;
                        depth_next    = depth_reg - DEPTH_W'(1);
                        len_next      = top;
                    end
                    held_next = 2'd0;
                    seen_next = 2'd0;
                end
                else
                begin
                    if (seen_reg == 2'd0)
                    begin
                        if (is_dot)
                        begin
                            held_next = 2'd1;
                        end
                        else
                        begin
                            open_comp = 1'b1;
                            put_c     = 1'b1;
                        end
                    end
                    else if (held_reg != 2'd0)
                    begin
                        if (is_dot && (held_reg == 2'd1))
                        begin
                            held_next = 2'd2;
                        end
                        else
                        begin
                            open_comp = 1'b1;
                            put_c     = 1'b1;
                            ndots     = held_reg;
                            held_next = 2'd0;
                        end
                    end
                    else
                    begin
                        put_c = 1'b1;
                    end
                    seen_next = (seen_reg == 2'd3) ? 2'd3 : seen_reg + 2'd1;

                    depth_err = open_comp && (depth_reg >= DEPTH_W'(MAX_DEPTH));
                    slash     = open_comp && (len_reg != '0);
                    n_bytes   = put_c ? ({2'b00, slash} + {1'b0, ndots} + 3'd1) : 3'd0;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (k < int'(slash))
                        begin
                            seq[k] = CH_SLASH;
                        end
                        else if (k < int'(slash) + int'(ndots))
                        begin
                            seq[k] = CH_DOT;
                        end
                        else
                        begin
                            seq[k] = item.ch;
                        end
                    end

                    if (depth_err)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        n_put = (LEN_W'(n_bytes) <= room) ? n_bytes : room[2:0];
                        if (n_put != n_bytes)
                        begin
                            err_next = 1'b1;
                        end
                        if (open_comp && !(slash && (room == '0)))
                        begin
                            stack_req.push = 1'b1;
                            depth_next     = depth_reg + DEPTH_W'(1);
                        end
                        len_next = len_reg + LEN_W'(n_put);
                    end
                end
            end
            else if (is_end)
            begin
                if (!err_reg)
                begin
                    if (close_pop)
                    begin
                        stack_req.pop = 1'b1;
                        depth_next    = depth_reg - DEPTH_W'(1);
                        len_next      = top;
                    end
                    if (((close_pop) ? top : len_reg) == '0)
                    begin
                        base     = '0;
                        n_put    = 3'd1;
                        seq[0]   = CH_DOT;
                        len_next = LEN_W'(1);
                    end
                end
                held_next = 2'd0;
                seen_next = 2'd0;
                done_next = 1'b1;
            end
        end

        rd_depth          = depth_next - DEPTH_W'(2);
        stack_req.rd_addr = rd_depth[MARK_AW-1:0];
    end

    // spread up to four consecutive bytes over the banks
    always_comb
    begin
        kk  = '0;
        pos = '0;
        for (int b = 0; b < BANKS; b++)
        begin
            kk         = BANK_SEL_W'(b) - base[BANK_SEL_W-1:0];
            pos        = base + LEN_W'(kk);
            wr[b].en   = ({1'b0, kk} < n_put);
            wr[b].addr = pos[LEN_W-1:BANK_SEL_W];
            wr[b].data = seq[kk];
        end
    end

    assign result.status   = err_next;
    assign result.length   = len_next;
    assign result.finished = done_next;
    assign result.hit      = is_read && (item.index < len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            depth_reg <= '0;
            seen_reg  <= '0;
            held_reg  <= '0;
            err_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            depth_reg <= depth_next;
            seen_reg  <= seen_next;
            held_reg  <= held_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

@@ src/lexical_path_normalizer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Lexical path normalizer: takes one transfer per cycle on the slave side (a path
// character, an end of path or a result byte read) unless the master side stalls, and
// returns one registered result transfer for each when the master side is ready. State
// is updated on acceptance: the output bytes live in four byte-wide banks, so the up to
// four bytes one character may append ('/', held dots, the character) are written at
// once, and the component marks live in a stack memory whose top is kept in a register
// with the entry beneath it read ahead, so ".." pops finish on acceptance too. The
// stores need no clearing pass after reset; bytes past the current length read as zero.
module lexical_path_normalizer_unit
    import lpn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // ch[7:0], index[19:8], zero[23:20]
    input  wire logic [1:0]  s_tuser,  // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // status[0], length[12:1], byte_out[20:13],
                                       // finished[21], zero[23:22]
);

    item_t                item;
    logic                 accept;
    logic                 s1_move;
    logic [LEN_W-1:0]     top;
    stack_req_t           stack_req;
    byte_wr_t [BANKS-1:0] wr;
    result_t              result;
    logic [7:0]           rd_byte;

    logic                 s1_valid_reg;
    result_t              s1_res_reg;
    logic                 m_valid_reg;
    logic [23:0]          m_data_reg;

    assign item.op    = op_t'(s_tuser);
    assign item.ch    = s_tdata[7:0];
    assign item.index = s_tdata[19:8];

    assign s1_move  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;

    lpn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .top       (top),
        .stack_req (stack_req),
        .wr        (wr),
        .result    (result)
    );

    lpn_mark_stack u_mark_stack (
        .clk (clk),
        .req (stack_req),
        .top (top)
    );

    lpn_out_buf u_out_buf (
        .clk      (clk),
        .wr       (wr),
        .rd_en    (accept && (item.op != OP_CHAR) && (item.op != OP_END)),
        .rd_index (item.index),
        .rd_byte  (rd_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= result;
        end
        if (s1_move)
        begin
            m_data_reg <= {2'b00, s1_res_reg.finished,
                           (s1_res_reg.hit ? rd_byte : 8'h00),
                           s1_res_reg.length, s1_res_reg.status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ src/lpn_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lpn_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    logic m_xfer;
    logic fin_seen_reg;
    logic err_seen_reg;

    assign m_xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_seen_reg <= 1'b0;
            err_seen_reg <= 1'b0;
        end
        else if (m_xfer)
        begin
            fin_seen_reg <= fin_seen_reg || m_tdata[21];
            err_seen_reg <= err_seen_reg || m_tdata[0];
        end
    end

    a_hold_valid : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_sticky : assert property (@(posedge clk) disable iff (!rst_n)
        m_xfer |-> (!fin_seen_reg || m_tdata[21]) && (!err_seen_reg || m_tdata[0]))
        else $error("finished or error flag cleared");

    a_byte_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[20:13] != 8'h00) |-> (m_tdata[12:1] != 12'h000))
        else $error("byte returned from empty result");

    a_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[21] && !m_tdata[0] |-> (m_tdata[12:1] != 12'h000))
        else $error("finished path without error is empty");

endmodule

bind lexical_path_normalizer_unit lpn_checker u_lpn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
